// ===== hdl/cubic_bezier_eval_and_length_defines.svh =====
// Assertion macros for the cubic Bezier evaluation and length block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CUBIC_BEZIER_EVAL_AND_LENGTH_DEFINES_SVH
`define CUBIC_BEZIER_EVAL_AND_LENGTH_DEFINES_SVH
`ifndef SYNTH
`define CBEL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbel same-cycle check failed");
`define CBEL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbel next-cycle check failed");
`else
`define CBEL_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CBEL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/cbel_pkg.sv =====
// Shared constants, types and helpers of the cubic Bezier evaluation block.
// No dependencies; used by cbel_casteljau and cubic_bezier_eval_and_length.
`default_nettype none
package cbel_pkg;
  localparam int COORD_BITS_DEF      = 21;
  localparam int T_FRACTION_BITS_DEF = 16;
  localparam int MAX_SEGMENTS_DEF    = 64;
  localparam int GUARD_BITS          = 16;
  localparam int OUT_COORD_W         = 21;
  localparam int CFG_W               = 63;
  localparam int CFG_IDX_W           = 3;
  localparam int NUM_CTRL            = 4;
  localparam int PARAM_T_W           = 17;
  localparam int SEG_IN_W            = 7;
  localparam int LEN_W               = 32;
  localparam logic [LEN_W-1:0] LEN_RESET = 32'd256;
  localparam int S_TDATA_W           = 24;
  localparam int M_TDATA_W           = 96;
  localparam int LERP_STEPS          = 6;
  localparam logic OP_EVAL           = 1'b0;
  localparam logic OP_MEASURE        = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  // Point slot updated by each of the six de Casteljau interpolations.
  function automatic logic [1:0] lerp_index(input logic [2:0] step);
    logic [1:0] idx;
    case (step)
      3'd0: idx = 2'd0;
      3'd1: idx = 2'd1;
      3'd2: idx = 2'd2;
      3'd3: idx = 2'd0;
      3'd4: idx = 2'd1;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/cbel_casteljau.sv =====
// Iterative de Casteljau point evaluator: one shared multiplier, each lerp a multiply state then an add state.
// Depends on cbel_pkg and the assertion macro header.
`default_nettype none
`include "cubic_bezier_eval_and_length_defines.svh"
module cbel_casteljau #(
  parameter int COORD_BITS      = cbel_pkg::COORD_BITS_DEF,
  parameter int T_FRACTION_BITS = cbel_pkg::T_FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [T_FRACTION_BITS:0]     t,
  input  wire logic [cbel_pkg::CFG_W-1:0]   ctrl [cbel_pkg::NUM_CTRL],
  output logic signed [COORD_BITS-1:0]      pt [3],
  output cbel_pkg::eng_stat_t               stat
);
  localparam int PW    = COORD_BITS + cbel_pkg::GUARD_BITS;
  localparam int DW    = PW + 1;
  localparam int TSW   = T_FRACTION_BITS + 2;
  localparam int PRODW = DW + TSW;
  localparam logic [PRODW-1:0] PROD_HALF = PRODW'(1) << (T_FRACTION_BITS - 1);
  localparam logic [PW-1:0]    FIN_HALF  = PW'(1) << (cbel_pkg::GUARD_BITS - 1);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_LOAD = 3'd1;
  localparam logic [2:0] E_MUL  = 3'd2;
  localparam logic [2:0] E_ADD  = 3'd3;
  localparam logic [2:0] E_FIN  = 3'd4;

  logic [2:0]                 state;
  logic [1:0]                 k;
  logic [2:0]                 step;
  logic                       done;
  logic signed [PW-1:0]       p [4];
  logic signed [PRODW-1:0]    prod;
  logic [T_FRACTION_BITS:0]   t_r;

  logic [1:0]                 idx;
  logic [1:0]                 idx_n;
  logic signed [DW-1:0]       diff;
  logic signed [TSW-1:0]      t_s;
  logic signed [PRODW-1:0]    prod_sh;
  logic [DW-1:0]              p_sum;
  logic signed [PW-1:0]       fin_sh;

  always_comb begin
    idx     = cbel_pkg::lerp_index(step);
    idx_n   = idx + 2'd1;
    diff    = {p[idx_n][PW-1], p[idx_n]} - {p[idx][PW-1], p[idx]};
    t_s     = {1'b0, t_r};
    prod_sh = (prod + $signed(PROD_HALF)) >>> T_FRACTION_BITS;
    p_sum   = {p[idx][PW-1], p[idx]} + prod_sh[DW-1:0];
    fin_sh  = (p[0] + $signed(FIN_HALF)) >>> cbel_pkg::GUARD_BITS;
  end

  assign stat.busy = (state != E_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
      k     <= 2'd0;
      step  <= 3'd0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (start) begin
            k     <= 2'd0;
            state <= E_LOAD;
          end
        end
        E_LOAD: begin
          step  <= 3'd0;
          state <= E_MUL;
        end
        E_MUL: begin
          state <= E_ADD;
        end
        E_ADD: begin
          if (step == 3'(cbel_pkg::LERP_STEPS - 1)) begin
            state <= E_FIN;
          end else begin
            step  <= step + 3'd1;
            state <= E_MUL;
          end
        end
        E_FIN: begin
          if (k == 2'd2) begin
            done  <= 1'b1;
            state <= E_IDLE;
          end else begin
            k     <= k + 2'd1;
            state <= E_LOAD;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      t_r <= t;
    end
    if (state == E_LOAD) begin
      for (int i = 0; i < cbel_pkg::NUM_CTRL; i++) begin
        p[i] <= {ctrl[i][int'(k) * COORD_BITS +: COORD_BITS],
                 {cbel_pkg::GUARD_BITS{1'b0}}};
      end
    end
    if (state == E_MUL) begin
      prod <= diff * t_s;
    end
    if (state == E_ADD) begin
      p[idx] <= p_sum[PW-1:0];
    end
    if (state == E_FIN) begin
      pt[k] <= fin_sh[COORD_BITS-1:0];
    end
  end

  `CBEL_ASSERT_SAME(a_start_idle, clk, rst, start, state == E_IDLE)
  `CBEL_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `CBEL_ASSERT_NEXT(a_start_loads, clk, rst, start, state == E_LOAD && k == 2'd0)
endmodule
`default_nettype wire

// ===== hdl/cubic_bezier_eval_and_length.sv =====
// Top level of the cubic Bezier block: control points, sequencer, divider, sqrt.
// Depends on cbel_pkg, cbel_casteljau and the assertion macro header.
//
//  channel  | direction | content
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser operation; tdata param_t, segments
//  m_*      | out       | tdata point_x, point_y, point_z, curve_length
//  cfg_*    | in        | write enable, register index, 63-bit write data
//
// Evaluate: the point unit works through the three coordinates in turn, each with a load,
// six lerps (a multiply on the shared multiplier, then an add) and a rounding.
// Measure with n segments: each segment takes 23 divider steps for t_i (SEG_W +
// T_FRACTION_BITS), a point evaluation, the squaring and summing of the deltas and
// 22 square-root steps (COORD_BITS + 1). Reset is synchronous; s_tready is high
// only while idle. A result waits in the output register while m_tready is low, and the
// next transaction is taken meanwhile.
`default_nettype none
`include "cubic_bezier_eval_and_length_defines.svh"
module cubic_bezier_eval_and_length #(
  parameter int COORD_BITS      = cbel_pkg::COORD_BITS_DEF,
  parameter int T_FRACTION_BITS = cbel_pkg::T_FRACTION_BITS_DEF,
  parameter int MAX_SEGMENTS    = cbel_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [16:0] param_t, [23:17] segments
  input  wire logic [cbel_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] operation
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [20:0] point_x, [41:21] point_y, [62:42] point_z, [94:63] curve_length, [95] zero
  output logic [cbel_pkg::M_TDATA_W-1:0]         m_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [cbel_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbel_pkg::CFG_W-1:0]        cfg_wdata
);
  localparam int TW     = T_FRACTION_BITS + 1;
  localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int NW     = SEG_W + T_FRACTION_BITS;
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int SQI    = COORD_BITS + 1;
  localparam int CNT_W  = $clog2((NW > SQI) ? NW : SQI);
  localparam int LW     = cbel_pkg::LEN_W;
  localparam int OCW    = cbel_pkg::OUT_COORD_W;
  localparam logic [TW-1:0]   T_ONE   = TW'(1) << T_FRACTION_BITS;
  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (SQ_W - 2);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_M_PT   = 3'd2;
  localparam logic [2:0] ST_M_DIV  = 3'd3;
  localparam logic [2:0] ST_M_SQR  = 3'd4;
  localparam logic [2:0] ST_M_SQRT = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]                  state;
  logic [cbel_pkg::CFG_W-1:0]  ctrl [cbel_pkg::NUM_CTRL];
  logic [LW-1:0]               stored_len;
  logic [LW-1:0]               sum;
  logic [SEG_W-1:0]            n_r;
  logic [SEG_W-1:0]            seg_i;
  logic [CNT_W-1:0]            cnt;
  logic                        meas_r;
  logic                        eng_start;
  logic [TW-1:0]               eng_t;
  logic signed [COORD_BITS-1:0] eng_pt [3];
  cbel_pkg::eng_stat_t         eng_stat;

  logic [NW-1:0]               num;
  logic [SEG_W-1:0]            rem;
  logic signed [COORD_BITS-1:0] prev [3];
  logic [SQ_W-1:0]             sqacc;
  logic [SQ_W-1:0]             sqprod;
  logic [SQ_W-1:0]             v;
  logic [SQ_W-1:0]             res;
  logic [SQ_W-1:0]             bitm;
  logic signed [OCW-1:0]       out_x;
  logic signed [OCW-1:0]       out_y;
  logic signed [OCW-1:0]       out_z;
  logic [LW-1:0]               out_len;

  logic [cbel_pkg::PARAM_T_W-1:0] in_t;
  logic [cbel_pkg::SEG_IN_W-1:0]  in_seg;
  logic [SEG_W:0]              trial;
  logic                        q_bit;
  logic [SEG_W-1:0]            rem_n;
  logic [NW-1:0]               num_n;
  logic signed [COORD_BITS:0]  dsel;
  logic signed [SQ_W-1:0]      dsq;
  logic [SQ_W-1:0]             rb;
  logic [SQ_W-1:0]             res_n;
  logic [LW:0]                 sum_wide;
  logic [LW-1:0]               sum_sat;
  logic                        out_free;
  logic                        seg_last;

  assign in_t   = s_tdata[cbel_pkg::PARAM_T_W-1:0];
  assign in_seg = s_tdata[cbel_pkg::PARAM_T_W +: cbel_pkg::SEG_IN_W];

  cbel_casteljau #(
    .COORD_BITS      (COORD_BITS),
    .T_FRACTION_BITS (T_FRACTION_BITS)
  ) u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (eng_start),
    .t     (eng_t),
    .ctrl  (ctrl),
    .pt    (eng_pt),
    .stat  (eng_stat)
  );

  always_comb begin
    // One restoring step of i * 2^T_FRACTION_BITS / n.
    trial = {rem, num[NW-1]};
    q_bit = (trial >= {1'b0, n_r});
    rem_n = q_bit ? SEG_W'(trial - {1'b0, n_r}) : trial[SEG_W-1:0];
    num_n = {num[NW-2:0], q_bit};
    dsel  = {eng_pt[cnt[1:0]][COORD_BITS-1], eng_pt[cnt[1:0]]}
          - {prev[cnt[1:0]][COORD_BITS-1], prev[cnt[1:0]]};
    dsq   = dsel * dsel;
    rb    = res + bitm;
    res_n = (v >= rb) ? ((res >> 1) + bitm) : (res >> 1);
    sum_wide = {1'b0, sum} + (LW + 1)'(res_n);
    sum_sat  = sum_wide[LW] ? {LW{1'b1}} : sum_wide[LW-1:0];
    out_free = !m_tvalid || m_tready;
    seg_last = (seg_i == n_r);
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {1'b0, out_len, out_z, out_y, out_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      stored_len <= cbel_pkg::LEN_RESET;
      m_tvalid   <= 1'b0;
      eng_start  <= 1'b0;
      for (int i = 0; i < cbel_pkg::NUM_CTRL; i++) begin
        ctrl[i] <= '0;
      end
    end else begin
      eng_start <= (state == ST_IDLE && s_tvalid) ||
                   (state == ST_M_DIV && cnt == CNT_W'(NW - 1));
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr_en && int'(cfg_index) < cbel_pkg::NUM_CTRL) begin
        ctrl[cfg_index[1:0]] <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == cbel_pkg::OP_MEASURE) ? ST_M_PT : ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eng_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_M_PT: begin
          if (eng_stat.done) begin
            state <= (seg_i == '0) ? ST_M_DIV : ST_M_SQR;
          end
        end
        ST_M_DIV: begin
          if (cnt == CNT_W'(NW - 1)) begin
            state <= ST_M_PT;
          end
        end
        ST_M_SQR: begin
          if (cnt == CNT_W'(3)) begin
            state <= ST_M_SQRT;
          end
        end
        ST_M_SQRT: begin
          if (cnt == CNT_W'(SQI - 1)) begin
            if (seg_last) begin
              stored_len <= sum_sat;
              state      <= ST_OUT;
            end else begin
              state <= ST_M_DIV;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers; the sequencer state above decides when they load.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt    <= '0;
        seg_i  <= '0;
        sum    <= '0;
        meas_r <= (s_tuser == cbel_pkg::OP_MEASURE);
        if (int'(in_seg) == 0) begin
          n_r <= SEG_W'(1);
        end else if (int'(in_seg) > MAX_SEGMENTS) begin
          n_r <= SEG_W'(MAX_SEGMENTS);
        end else begin
          n_r <= SEG_W'(in_seg);
        end
        if (s_tuser == cbel_pkg::OP_MEASURE) begin
          eng_t <= '0;
        end else if (int'(in_t) > (1 << T_FRACTION_BITS)) begin
          eng_t <= T_ONE;
        end else begin
          eng_t <= TW'(in_t);
        end
      end
      ST_M_PT: begin
        cnt   <= '0;
        sqacc <= '0;
        if (eng_stat.done && seg_i == '0) begin
          prev  <= eng_pt;
          seg_i <= SEG_W'(1);
          num   <= NW'(1) << T_FRACTION_BITS;
          rem   <= '0;
        end
      end
      ST_M_DIV: begin
        num <= num_n;
        rem <= rem_n;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          eng_t <= TW'(num_n);
        end
      end
      ST_M_SQR: begin
        if (cnt != CNT_W'(3)) begin
          sqprod <= SQ_W'(dsq);
        end
        if (cnt != '0) begin
          sqacc <= sqacc + sqprod;
        end
        if (cnt == CNT_W'(3)) begin
          v    <= sqacc + sqprod;
          res  <= '0;
          bitm <= SQ_BIT0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_M_SQRT: begin
        if (v >= rb) begin
          v <= v - rb;
        end
        res  <= res_n;
        bitm <= bitm >> 2;
        if (cnt == CNT_W'(SQI - 1)) begin
          sum   <= sum_sat;
          prev  <= eng_pt;
          cnt   <= '0;
          rem   <= '0;
          seg_i <= seg_i + SEG_W'(1);
          num   <= NW'(seg_i + SEG_W'(1)) << T_FRACTION_BITS;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_len <= stored_len;
          if (meas_r) begin
            out_x <= '0;
            out_y <= '0;
            out_z <= '0;
          end else begin
            out_x <= OCW'(eng_pt[0]);
            out_y <= OCW'(eng_pt[1]);
            out_z <= OCW'(eng_pt[2]);
          end
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  `CBEL_ASSERT_SAME(a_done_when_waiting, clk, rst, eng_stat.done,
                    state == ST_EVAL || state == ST_M_PT)
  `CBEL_ASSERT_SAME(a_seg_in_range, clk, rst, state == ST_M_DIV,
                    seg_i != '0 && seg_i <= n_r)
  `CBEL_ASSERT_NEXT(a_out_holds, clk, rst, state == ST_OUT && m_tvalid && !m_tready,
                    state == ST_OUT)
  `CBEL_ASSERT_SAME(a_start_engine_idle, clk, rst, eng_start, !eng_stat.busy)
endmodule
`default_nettype wire
